/* rtl/core/trnm_pkg.sv */
// Shared types, constants and helpers for the token ring station MAC.
// No dependencies; imported by token_ring_node_mac_top and trnm_rq.
package trnm_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned POS_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W       = 7;

  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned CNT_W    = RQ_AW + 1;

  localparam logic [1:0] FUNC_RING = 2'd0;
  localparam logic [1:0] FUNC_HDR  = 2'd1;
  localparam logic [1:0] FUNC_DATA = 2'd2;

  localparam logic KIND_RING = 1'b0;
  localparam logic KIND_HOST = 1'b1;

  localparam logic [7:0] TOKEN_CH = 8'h2F;
  localparam logic [7:0] START_CH = 8'h2B;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_DEST = 5'b00010,
    PH_SRC  = 5'b00100,
    PH_LEN  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       ring_byte;
    logic [7:0]       dest_addr;
    logic [7:0]       src_addr;
    logic [LEN_W-1:0] tx_length;
    logic [5:0]       data_index;
    logic [7:0]       data_value;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  out_byte;
    logic        frame_last;
    logic        own_frame_stripped;
    logic [15:0] rx_count;
    logic [15:0] tx_count;
  } result_t;

  typedef struct packed {
    logic [1:0]                 num;
    result_t [MAX_RES-1:0]      res;
  } res_bus_t;

  function automatic result_t mk_res(logic kind, logic [7:0] byte_v, logic last,
                                     logic strip, logic [15:0] rxc, logic [15:0] txc);
    result_t r;
    r.out_kind           = kind;
    r.out_byte           = byte_v;
    r.frame_last         = last;
    r.own_frame_stripped = strip;
    r.rx_count           = rxc;
    r.tx_count           = txc;
    return r;
  endfunction

endpackage

/* rtl/core/token_ring_node_mac_top.sv */
// Top level of the token ring station MAC: input register, frame logic, tx buffer.
// Depends on trnm_pkg, trnm_ram and trnm_rq.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one item per
// accepted edge: a ring byte, a packet header load or a transmit data load.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries results:
// bytes sent on to the next station and data bytes delivered to the host.
// node_id is written through cfg_we_i / cfg_wdata_i; the user must write it only
// while the block is idle, as the block itself does not enforce this. An accepted
// item waits in the input register and is processed once the result queue has
// room for all of its results, which go into the result queue and are shown from
// there. Host loads and ring bytes that give no result go at one item per cycle; a
// ring byte gives up to three results and the four-entry result queue drains one
// per cycle while the receiver does not stall, so three-result items wait on it.
// Reset clears all frame state and counters and emits nothing; the first
// token comes from the ring. The tx buffer holds garbage until loaded.
// When the receiver stalls, results collect in the queue; once it lacks room
// the input register holds its item and in_stall_o goes high.
module token_ring_node_mac_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  trnm_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output trnm_pkg::result_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);
  import trnm_pkg::*;

  logic       in_valid_q;
  in_item_t   in_q;
  logic       in_accept;
  logic       fire;
  logic [7:0] node_id_q;

  phase_e           rx_phase_q, rx_phase_d, tx_phase_q, tx_phase_d;
  logic             sending_q, sending_d, stripping_q, stripping_d;
  logic             pending_q, pending_d;
  logic [LEN_W-1:0] tx_rem_q, tx_rem_d, hdr_len_q, hdr_len_d;
  logic [POS_W-1:0] tx_pos_q, tx_pos_d;
  logic [7:0]       rx_rem_q, rx_rem_d, rx_dest_q, rx_dest_d;
  logic [7:0]       hdr_dest_q, hdr_dest_d, hdr_src_q, hdr_src_d;
  logic [15:0]      rx_cnt_q, rx_cnt_d, tx_cnt_q, tx_cnt_d;

  logic                  fwd, here, rx_end, strip_sig;
  logic [1:0]            n_res;
  result_t [MAX_RES-1:0] res_v;
  res_bus_t              push;
  logic [CNT_W-1:0]      rq_free;

  logic             buf_we;
  logic [POS_W-1:0] buf_raddr;
  logic [7:0]       buf_rdata;

  // input register
  assign fire       = in_valid_q & (CNT_W'(n_res) <= rq_free);
  assign in_stall_o = in_valid_q & ~fire;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept | (in_valid_q & ~fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0;
    end else if (cfg_we_i) begin
      node_id_q <= cfg_wdata_i;
    end
  end

  // one item's work; committed only when fire
  always_comb begin
    rx_phase_d  = rx_phase_q;
    tx_phase_d  = tx_phase_q;
    sending_d   = sending_q;
    stripping_d = stripping_q;
    pending_d   = pending_q;
    tx_rem_d    = tx_rem_q;
    tx_pos_d    = tx_pos_q;
    rx_rem_d    = rx_rem_q;
    rx_dest_d   = rx_dest_q;
    hdr_dest_d  = hdr_dest_q;
    hdr_src_d   = hdr_src_q;
    hdr_len_d   = hdr_len_q;
    rx_cnt_d    = rx_cnt_q;
    tx_cnt_d    = tx_cnt_q;
    fwd         = 1'b0;
    here        = 1'b0;
    rx_end      = 1'b0;
    strip_sig   = 1'b0;
    n_res       = '0;
    res_v       = '0;
    buf_we      = 1'b0;

    case (in_q.func)
      FUNC_HDR: begin
        hdr_dest_d = in_q.dest_addr;
        hdr_src_d  = in_q.src_addr;
        hdr_len_d  = (in_q.tx_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                            : in_q.tx_length;
        pending_d  = 1'b1;
      end
      FUNC_DATA: begin
        buf_we = (int'(in_q.data_index) < MAX_PAYLOAD);
      end
      FUNC_RING: begin
        // transmit side first
        if (sending_d) begin
          case (tx_phase_d)
            PH_IDLE: begin
              tx_phase_d   = PH_DEST;
              res_v[n_res] = mk_res(KIND_RING, START_CH, 1'b0, 1'b0, rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end
            PH_DEST: begin
              tx_phase_d   = PH_SRC;
              res_v[n_res] = mk_res(KIND_RING, hdr_dest_d, 1'b0, 1'b0, rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end
            PH_SRC: begin
              tx_phase_d   = PH_LEN;
              res_v[n_res] = mk_res(KIND_RING, hdr_src_d, 1'b0, 1'b0, rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end
            PH_LEN: begin
              tx_rem_d     = hdr_len_d;
              tx_pos_d     = '0;
              res_v[n_res] = mk_res(KIND_RING, 8'(hdr_len_d), 1'b0, 1'b0,
                                    rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
              if (tx_rem_d == '0) begin
                tx_cnt_d     = tx_cnt_d + 16'd1;
                pending_d    = 1'b0;
                sending_d    = 1'b0;
                stripping_d  = 1'b1;
                hdr_len_d    = '0;
                tx_phase_d   = PH_IDLE;
                res_v[n_res] = mk_res(KIND_RING, TOKEN_CH, 1'b0, 1'b0, rx_cnt_d, tx_cnt_d);
                n_res        = n_res + 2'd1;
              end else begin
                tx_phase_d = PH_DATA;
              end
            end
            default: begin
              if (tx_rem_d != '0) begin
                res_v[n_res] = mk_res(KIND_RING, buf_rdata, 1'b0, 1'b0,
                                      rx_cnt_d, tx_cnt_d);
                n_res        = n_res + 2'd1;
                tx_pos_d     = tx_pos_d + POS_W'(1);
                tx_rem_d     = tx_rem_d - LEN_W'(1);
              end
              if (tx_rem_d == '0) begin
                tx_cnt_d     = tx_cnt_d + 16'd1;
                pending_d    = 1'b0;
                sending_d    = 1'b0;
                stripping_d  = 1'b1;
                hdr_len_d    = '0;
                tx_phase_d   = PH_IDLE;
                res_v[n_res] = mk_res(KIND_RING, TOKEN_CH, 1'b0, 1'b0, rx_cnt_d, tx_cnt_d);
                n_res        = n_res + 2'd1;
              end
            end
          endcase
        end

        fwd = ~stripping_d & ~sending_d;

        // receive side
        case (rx_phase_d)
          PH_IDLE: begin
            if (in_q.ring_byte == TOKEN_CH) begin
              if (pending_d) begin
                sending_d  = 1'b1;
                tx_phase_d = PH_IDLE;
              end else begin
                res_v[n_res] = mk_res(KIND_RING, in_q.ring_byte, 1'b0, 1'b0,
                                      rx_cnt_d, tx_cnt_d);
                n_res        = n_res + 2'd1;
              end
            end else if (in_q.ring_byte == START_CH) begin
              if (fwd) begin
                res_v[n_res] = mk_res(KIND_RING, in_q.ring_byte, 1'b0, 1'b0,
                                      rx_cnt_d, tx_cnt_d);
                n_res        = n_res + 2'd1;
              end
              rx_phase_d = PH_DEST;
            end
          end
          PH_DEST: begin
            rx_dest_d = in_q.ring_byte;
            if (in_q.ring_byte == node_id_q) begin
              rx_cnt_d = rx_cnt_d + 16'd1;
            end
            if (fwd) begin
              res_v[n_res] = mk_res(KIND_RING, in_q.ring_byte, 1'b0, 1'b0,
                                    rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end
            rx_phase_d = PH_SRC;
          end
          PH_SRC: begin
            if (fwd) begin
              res_v[n_res] = mk_res(KIND_RING, in_q.ring_byte, 1'b0, 1'b0,
                                    rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end
            rx_phase_d = PH_LEN;
          end
          PH_LEN: begin
            rx_rem_d = in_q.ring_byte;
            if (fwd) begin
              res_v[n_res] = mk_res(KIND_RING, in_q.ring_byte, 1'b0, 1'b0,
                                    rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end
            if (in_q.ring_byte != '0) begin
              rx_phase_d = PH_DATA;
            end else begin
              strip_sig = stripping_d & ~sending_d;
              if (strip_sig) begin
                res_v[n_res] = mk_res(KIND_HOST, 8'h00, 1'b0, 1'b1, rx_cnt_d, tx_cnt_d);
                n_res        = n_res + 2'd1;
              end
              stripping_d = 1'b0;
              rx_phase_d  = PH_IDLE;
            end
          end
          default: begin
            here = (rx_dest_d == node_id_q);
            if (fwd) begin
              res_v[n_res] = mk_res(KIND_RING, in_q.ring_byte, 1'b0, 1'b0,
                                    rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end
            if (rx_rem_d != '0) begin
              rx_rem_d = rx_rem_d - 8'd1;
            end
            rx_end    = (rx_rem_d == '0);
            strip_sig = rx_end & stripping_d & ~sending_d;
            if (here) begin
              res_v[n_res] = mk_res(KIND_HOST, in_q.ring_byte, rx_end, strip_sig,
                                    rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end else if (strip_sig) begin
              res_v[n_res] = mk_res(KIND_HOST, 8'h00, 1'b0, 1'b1, rx_cnt_d, tx_cnt_d);
              n_res        = n_res + 2'd1;
            end
            if (rx_end) begin
              stripping_d = 1'b0;
              rx_phase_d  = PH_IDLE;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign push.num = fire ? n_res : 2'd0;
  assign push.res = res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase_q  <= PH_IDLE;
      tx_phase_q  <= PH_IDLE;
      sending_q   <= 1'b0;
      stripping_q <= 1'b0;
      pending_q   <= 1'b0;
      tx_rem_q    <= '0;
      tx_pos_q    <= '0;
      rx_rem_q    <= '0;
      rx_dest_q   <= '0;
      hdr_dest_q  <= '0;
      hdr_src_q   <= '0;
      hdr_len_q   <= '0;
      rx_cnt_q    <= '0;
      tx_cnt_q    <= '0;
    end else if (fire) begin
      rx_phase_q  <= rx_phase_d;
      tx_phase_q  <= tx_phase_d;
      sending_q   <= sending_d;
      stripping_q <= stripping_d;
      pending_q   <= pending_d;
      tx_rem_q    <= tx_rem_d;
      tx_pos_q    <= tx_pos_d;
      rx_rem_q    <= rx_rem_d;
      rx_dest_q   <= rx_dest_d;
      hdr_dest_q  <= hdr_dest_d;
      hdr_src_q   <= hdr_src_d;
      hdr_len_q   <= hdr_len_d;
      rx_cnt_q    <= rx_cnt_d;
      tx_cnt_q    <= tx_cnt_d;
    end
  end

  // read address tracks the position that holds after this cycle
  assign buf_raddr = fire ? tx_pos_d : tx_pos_q;

  trnm_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_txbuf (
    .clk_i  (clk_i),
    .we_i   (buf_we & fire),
    .waddr_i(in_q.data_index[POS_W-1:0]),
    .wdata_i(in_q.data_value),
    .raddr_i(buf_raddr),
    .rdata_o(buf_rdata)
  );

  trnm_rq u_rq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .free_o     (rq_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (tx_phase_q == PH_IDLE))
    else $error("tx phase advanced without transmission");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_rem_q <= LEN_W'(MAX_PAYLOAD)) && (hdr_len_q <= LEN_W'(MAX_PAYLOAD)))
    else $error("tx length beyond max payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(rx_cnt_q) && $stable(tx_cnt_q)))
    else $error("counter moved without a processed item");

endmodule

/* rtl/core/trnm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Write-through on a same-address read and write. No dependencies.
module trnm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/trnm_rq.sv */
// Result queue: takes up to MAX_RES per cycle, gives one per cycle unless stalled.
// Depends on trnm_pkg.
module trnm_rq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  trnm_pkg::res_bus_t        push_i,
  output logic [trnm_pkg::CNT_W-1:0] free_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output trnm_pkg::result_t         out_data_o
);
  import trnm_pkg::*;

  result_t          mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o & ~out_stall_i;
  assign free_o      = CNT_W'(RQ_DEPTH) - cnt_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(push_i.num)) begin
        mem_q[wr_q + RQ_AW'(k)] <= push_i.res[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + RQ_AW'(push_i.num);
      rd_q  <= rd_q + RQ_AW'(pop);
      cnt_q <= cnt_q + CNT_W'(push_i.num) - CNT_W'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RQ_DEPTH))
    else $error("result queue over depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(push_i.num) <= free_o)
    else $error("result queue push exceeds free slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (rd_q == $past(rd_q)))
    else $error("result queue head moved while stalled");

endmodule
